[rtl/core/wbs_pkg.sv]
// Package for the word boundary text search: shared constants, codes and
// byte classification helpers.
// Depends on nothing; every other file of the block but wbs_if imports it.
package wbs_pkg;

  // Default sizes handed down from the top level.
  localparam int unsigned MAX_WORD_DEF    = 16;
  localparam int unsigned MAX_TEXT_DEF    = 65536;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned WLEN_W      = 5;
  localparam int unsigned OFFSET_W    = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_WORD_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WORD_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WORD_LEN  = 2'd2;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] word_low;
    logic [CFG_DATA_W-1:0] word_high;
    logic [WLEN_W-1:0]     word_len;
  } cfg_t;

  // Token class state codes.
  localparam int unsigned TOK_W = 2;
  localparam logic [TOK_W-1:0] CLS_START  = 2'd0;
  localparam logic [TOK_W-1:0] CLS_DIGIT  = 2'd1;
  localparam logic [TOK_W-1:0] CLS_LETTER = 2'd2;
  localparam logic [TOK_W-1:0] CLS_SKIP   = 2'd3;

  // What the front part makes of one incoming byte.
  typedef enum logic [1:0] {
    KIND_KEEP,
    KIND_END,
    KIND_IGNORE
  } kind_e;

  // Queue entry width apart from the position field: kind, byte and last.
  localparam int unsigned ENTRY_FIXED_W = 2 + 8 + 1;

  // Character constants.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_STEP  = 8'h20;

  // Two-byte Latin letter ranges.
  localparam logic [7:0] LEAD_C3      = 8'hC3;
  localparam logic [7:0] LEAD_C4      = 8'hC4;
  localparam logic [7:0] LEAD_C9      = 8'hC9;
  localparam logic [7:0] LEAD_CA      = 8'hCA;
  localparam logic [7:0] TIMES_SIGN   = 8'h97;
  localparam logic [7:0] DIVIDE_SIGN  = 8'hB7;
  localparam logic [7:0] CONT_LOW     = 8'h80;
  localparam logic [7:0] CONT_HIGH    = 8'hBF;
  localparam logic [7:0] CA_CONT_HIGH = 8'hAF;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_ascii_letter(logic [7:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
  endfunction

  function automatic logic is_wide_letter(logic [7:0] lead, logic [7:0] nxt);
    logic cont;
    cont = (nxt >= CONT_LOW) && (nxt <= CONT_HIGH);
    if (!cont) return 1'b0;
    if (lead == LEAD_C3) return (nxt != TIMES_SIGN) && (nxt != DIVIDE_SIGN);
    if ((lead >= LEAD_C4) && (lead <= LEAD_C9)) return 1'b1;
    if (lead == LEAD_CA) return nxt <= CA_CONT_HIGH;
    return 1'b0;
  endfunction

  function automatic logic [TOK_W-1:0] classify(logic [7:0] cur, logic [7:0] nxt);
    if (is_digit(cur)) return CLS_DIGIT;
    if (is_ascii_letter(cur)) return CLS_LETTER;
    if (is_wide_letter(cur, nxt)) return CLS_SKIP;
    return CLS_START;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) return c + CASE_STEP;
    return c;
  endfunction

endpackage

[rtl/core/wbs_if.sv]
// Channel interfaces of the word boundary text search: the text byte
// channel and the result channel, each with valid/ready handshake.
// Depends on nothing.
interface wbs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last;

  modport source (output valid, text_byte, last, input ready);
  modport sink (input valid, text_byte, last, output ready);
endinterface

interface wbs_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] offset;

  modport source (output valid, found, offset, input ready);
  modport sink (input valid, found, offset, output ready);
endinterface

[rtl/core/wbs_front.sv]
// Front part of the word boundary text search: takes text bytes, tracks the
// text end and length cut, and pushes classified entries into the queue.
// Depends on wbs_pkg and wbs_if.
module wbs_front import wbs_pkg::*; #(
  parameter int unsigned MAX_TEXT = MAX_TEXT_DEF,
  localparam int unsigned POS_W   = $clog2(MAX_TEXT),
  localparam int unsigned ENTRY_W = ENTRY_FIXED_W + POS_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  wbs_byte_if.sink           text_i,
  output logic               push_o,
  output logic [ENTRY_W-1:0] push_data_o,
  input  logic               push_ready_i
);

  localparam int unsigned CNT_W = $clog2(MAX_TEXT + 1);

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       text_byte;
    logic             last;
    logic [POS_W-1:0] pos;
  } entry_t;

  logic             ended_q, ended_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fire;
  entry_t           entry;

  always_comb begin
    entry.text_byte = text_i.text_byte;
    entry.last      = text_i.last;
    entry.pos       = cnt_q[POS_W-1:0];
    if (ended_q) begin
      entry.kind = KIND_IGNORE;
    end else if ((text_i.text_byte == 8'd0) || (cnt_q >= CNT_W'(MAX_TEXT))) begin
      entry.kind = KIND_END;
    end else begin
      entry.kind = KIND_KEEP;
    end
  end

  // Bytes after the end of the text carry nothing, unless they close it.
  assign text_i.ready = push_ready_i;
  assign fire         = text_i.valid && push_ready_i;
  assign push_o       = fire && ((entry.kind != KIND_IGNORE) || text_i.last);
  assign push_data_o  = entry;

  always_comb begin
    ended_d = ended_q;
    cnt_d   = cnt_q;
    if (fire) begin
      if (text_i.last) begin
        ended_d = 1'b0;
        cnt_d   = '0;
      end else if (entry.kind == KIND_KEEP) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else if (entry.kind == KIND_END) begin
        ended_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      ended_q <= ended_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/core/wbs_fifo.sv]
// Short queue between the front and back parts of the word boundary text
// search. Depends on wbs_pkg for its default depth.
module wbs_fifo import wbs_pkg::*; #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [AW:0]       wr_q, rd_q;
  logic              full, empty, push, pop;

  assign empty       = (wr_q == rd_q);
  assign full        = (wr_q[AW-1:0] == rd_q[AW-1:0]) && (wr_q[AW] != rd_q[AW]);
  assign in_ready_o  = !full;
  assign out_valid_o = !empty;
  assign push        = in_valid_i && !full;
  assign pop         = out_ready_i && !empty;
  assign out_data_o  = mem_q[rd_q[AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q[AW-1:0]] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + (AW+1)'(1);
      if (pop) rd_q <= rd_q + (AW+1)'(1);
    end
  end

endmodule

[rtl/core/wbs_back.sv]
// Back part of the word boundary text search: holds the token state and the
// partial match vector, judges each byte once its successor is known, and
// registers the result. Depends on wbs_pkg and wbs_if.
module wbs_back import wbs_pkg::*; #(
  parameter int unsigned MAX_WORD = MAX_WORD_DEF,
  parameter int unsigned MAX_TEXT = MAX_TEXT_DEF,
  localparam int unsigned POS_W   = $clog2(MAX_TEXT),
  localparam int unsigned ENTRY_W = ENTRY_FIXED_W + POS_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               ent_valid_i,
  output logic               ent_ready_o,
  input  logic [ENTRY_W-1:0] ent_data_i,
  wbs_result_if.source       result_o
);

  localparam int unsigned LEN_W = $clog2(MAX_WORD + 1);

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       text_byte;
    logic             last;
    logic [POS_W-1:0] pos;
  } entry_t;

  typedef struct packed {
    logic [TOK_W-1:0]    tok;
    logic [MAX_WORD-1:0] pm;
    logic                seen;
    logic [OFFSET_W-1:0] mpos;
  } judge_t;

  // One byte judged: token step, candidate flag and match vector update.
  function automatic judge_t judge(judge_t s, logic [7:0] cur, logic [7:0] nxt,
                                   logic [POS_W-1:0] pos,
                                   logic [8*MAX_WORD-1:0] word,
                                   logic [LEN_W-1:0] len);
    judge_t              r;
    logic                cand;
    logic [7:0]          lc;
    logic [MAX_WORD-1:0] eq, live, sel;
    r    = s;
    cand = 1'b0;
    unique case (s.tok)
      CLS_DIGIT: begin
        if (is_digit(cur)) begin
          r.tok = CLS_DIGIT;
        end else if (cur == CH_SPACE) begin
          r.tok = CLS_START;
        end else begin
          cand  = 1'b1;
          r.tok = classify(cur, nxt);
        end
      end
      CLS_LETTER: begin
        if (is_ascii_letter(cur)) begin
          r.tok = CLS_LETTER;
        end else if (is_wide_letter(cur, nxt)) begin
          r.tok = CLS_SKIP;
        end else if (cur == CH_SPACE) begin
          r.tok = CLS_START;
        end else begin
          cand  = 1'b1;
          r.tok = classify(cur, nxt);
        end
      end
      CLS_SKIP: begin
        r.tok = CLS_LETTER;
      end
      CLS_START: begin
        if ((cur == CH_SPACE) && (pos != '0)) begin
          r.tok = CLS_START;
        end else begin
          cand  = 1'b1;
          r.tok = classify(cur, nxt);
        end
      end
      default: r.tok = CLS_START;
    endcase
    lc = to_lower(cur);
    for (int i = 0; i < MAX_WORD; i++) begin
      eq[i]  = (word[8*i +: 8] == lc) && (LEN_W'(i) < len);
      sel[i] = (len == LEN_W'(i + 1));
    end
    live = (s.pm | MAX_WORD'(cand)) & eq;
    if ((|(live & sel)) && !s.seen) begin
      r.seen = 1'b1;
      r.mpos = OFFSET_W'(pos - POS_W'(len) + POS_W'(1));
    end
    r.pm = live << 1;
    return r;
  endfunction

  localparam judge_t JUDGE_RESET = '{tok: CLS_START, pm: '0, seen: 1'b0, mpos: '0};

  entry_t                ent;
  logic [2*CFG_DATA_W-1:0] word_all;
  logic [8*MAX_WORD-1:0] word;
  logic [LEN_W-1:0]      len;
  judge_t                st_q, st_d, st_a, st_b;
  logic [7:0]            prev_q, prev_d;
  logic [POS_W-1:0]      prevpos_q, prevpos_d;
  logic                  pend_q, pend_d;
  logic                  do_a, do_b, fire;
  logic [7:0]            nxt_a;
  logic                  out_valid_q, found_q, found_d;
  logic [OFFSET_W-1:0]   offset_q, offset_d;

  assign ent      = ent_data_i;
  assign word_all = {cfg_i.word_high, cfg_i.word_low};
  assign word     = word_all[8*MAX_WORD-1:0];
  assign len      = (cfg_i.word_len > WLEN_W'(MAX_WORD)) ? LEN_W'(MAX_WORD)
                                                         : LEN_W'(cfg_i.word_len);

  // A result can only be taken into the output register once it is free.
  assign ent_ready_o = !(ent.last && out_valid_q && !result_o.ready);
  assign fire        = ent_valid_i && ent_ready_o;

  // The pending byte is judged against the new byte, or against an end.
  // A kept byte that also closes the text is judged straight after.
  assign do_a  = pend_q && (ent.kind != KIND_IGNORE || ent.last);
  assign nxt_a = (ent.kind == KIND_KEEP) ? ent.text_byte : 8'd0;
  assign do_b  = (ent.kind == KIND_KEEP) && ent.last;
  assign st_a  = do_a ? judge(st_q, prev_q, nxt_a, prevpos_q, word, len) : st_q;
  assign st_b  = do_b ? judge(st_a, ent.text_byte, 8'd0, ent.pos, word, len) : st_a;

  always_comb begin
    st_d      = st_q;
    prev_d    = prev_q;
    prevpos_d = prevpos_q;
    pend_d    = pend_q;
    found_d   = found_q;
    offset_d  = offset_q;
    if (fire) begin
      if (ent.last) begin
        st_d      = JUDGE_RESET;
        prev_d    = 8'd0;
        prevpos_d = '0;
        pend_d    = 1'b0;
        if (len == '0) begin
          found_d  = 1'b1;
          offset_d = '0;
        end else begin
          found_d  = st_b.seen;
          offset_d = st_b.seen ? st_b.mpos : '0;
        end
      end else begin
        st_d = st_b;
        case (ent.kind)
          KIND_KEEP: begin
            prev_d    = ent.text_byte;
            prevpos_d = ent.pos;
            pend_d    = 1'b1;
          end
          KIND_END: pend_d = 1'b0;
          default: pend_d = pend_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= JUDGE_RESET;
      prev_q      <= 8'd0;
      prevpos_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      prev_q    <= prev_d;
      prevpos_q <= prevpos_d;
      pend_q    <= pend_d;
      if (fire && ent.last) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    offset_q <= offset_d;
  end

  assign result_o.valid  = out_valid_q;
  assign result_o.found  = found_q;
  assign result_o.offset = offset_q;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ent.last) |=> (!pend_q && (st_q.tok == CLS_START) && (st_q.pm == '0)
                            && !st_q.seen))
    else $error("search state not cleared after the closing transaction");

  a_offset_zero_when_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (offset_q == '0))
    else $error("non-zero offset reported without a match");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire && ent.last))
    else $error("result raised without a closing queue entry");

endmodule

[rtl/core/word_boundary_text_search.sv]
// Word search at token starts over a byte stream. The block takes one text
// byte per cycle without pause, also across text boundaries, while the result
// side keeps up; once the last byte of a text is accepted, it passes through
// the queue, and the back part registers its result. A waiting result
// stalls the back part only at a following closing byte; ordinary text bytes
// keep being accepted until the queue in front of it is full. The rate is set
// by the back part, which judges one queue entry per cycle unless stalled; a
// four-entry queue between the front and back parts absorbs result stalls. A
// byte is judged once its successor is known, so the word match lags the
// input by one byte. Configure the word only while no text is in flight.
module word_boundary_text_search import wbs_pkg::*; #(
  parameter int unsigned MAX_WORD    = MAX_WORD_DEF,
  parameter int unsigned MAX_TEXT    = MAX_TEXT_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  wbs_byte_if.sink               text_i,
  wbs_result_if.source           result_o
);

  localparam int unsigned POS_W   = $clog2(MAX_TEXT);
  localparam int unsigned ENTRY_W = ENTRY_FIXED_W + POS_W;

  cfg_t               cfg_q;
  logic               push, push_ready, ent_valid, ent_ready;
  logic [ENTRY_W-1:0] push_data, ent_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WORD_LOW:  cfg_q.word_low  <= cfg_wdata_i;
        CFG_WORD_HIGH: cfg_q.word_high <= cfg_wdata_i;
        CFG_WORD_LEN:  cfg_q.word_len  <= cfg_wdata_i[WLEN_W-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  wbs_front #(
    .MAX_TEXT (MAX_TEXT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_i       (text_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  wbs_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .in_ready_o  (push_ready),
    .in_data_i   (push_data),
    .out_valid_o (ent_valid),
    .out_ready_i (ent_ready),
    .out_data_o  (ent_data)
  );

  wbs_back #(
    .MAX_WORD (MAX_WORD),
    .MAX_TEXT (MAX_TEXT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ent_valid_i (ent_valid),
    .ent_ready_o (ent_ready),
    .ent_data_i  (ent_data),
    .result_o    (result_o)
  );

endmodule
